@@ rtl/core/bopr_pkg.sv @@
package bopr_pkg;

  // Tree size and the widths that follow from it.
  localparam int MAX_STEPS  = 256;
  localparam int NODE_DEPTH = MAX_STEPS + 1;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int LVL_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // Fixed field widths.
  localparam int PRICE_W    = 32;
  localparam int FACT_W     = 32;
  localparam int PROB_W     = 31;
  localparam int NSTEPS_W   = 9;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 64;

  localparam logic [PROB_W-1:0]  ONE_Q30   = 31'h4000_0000;
  localparam logic [PRICE_W-1:0] PRICE_MAX = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_FACTOR   = 3'd0,
    CFG_DOWN_FACTOR = 3'd1,
    CFG_UP_PROB     = 3'd2,
    CFG_DISCOUNT    = 3'd3,
    CFG_NUM_STEPS   = 3'd4,
    CFG_EXERCISE    = 3'd5
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_L_UP,
    S_L_WR,
    S_B_RD,
    S_B_MP,
    S_B_MQ,
    S_B_SUM,
    S_B_DISC,
    S_B_SPOT,
    S_B_WB,
    S_DONE
  } state_e;

  // Write request into the node store.
  typedef struct packed {
    logic                en;
    logic [STEP_W-1:0]   addr;
    logic [PRICE_W-1:0]  value;
    logic                spot_en;
    logic [PRICE_W-1:0]  spot;
  } node_wr_t;

  // Read request into the node store: value and spot at addr_a, value at addr_b.
  typedef struct packed {
    logic              en;
    logic [STEP_W-1:0] addr_a;
    logic [STEP_W-1:0] addr_b;
  } node_rd_t;

  function automatic logic [PRICE_W-1:0] sat32(input logic [PROD_W-1:0] x);
    logic [PRICE_W-1:0] r;
    if (x[PROD_W-1:PRICE_W] != '0) begin
      r = PRICE_MAX;
    end else begin
      r = x[PRICE_W-1:0];
    end
    return r;
  endfunction

  // Price times Q2.30 factor, truncated and saturated.
  function automatic logic [PRICE_W-1:0] q30_scale(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] sh;
    sh = prod >> 30;
    return sat32(sh);
  endfunction

  function automatic logic [PRICE_W-1:0] call_payoff(input logic [PRICE_W-1:0] spot,
                                                     input logic [PRICE_W-1:0] strike);
    logic [PRICE_W-1:0] r;
    if (spot > strike) begin
      r = spot - strike;
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bopr_if.sv @@
interface bopr_req_if import bopr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] spot_price;
  logic [PRICE_W-1:0] strike_price;

  modport source (output valid, output spot_price, output strike_price, input ready);
  modport sink   (input valid, input spot_price, input strike_price, output ready);
endinterface

interface bopr_rsp_if import bopr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] option_price;

  modport source (output valid, output option_price, input ready);
  modport sink   (input valid, input option_price, output ready);
endinterface

@@ rtl/core/bopr_node_store.sv @@
module bopr_node_store import bopr_pkg::*; (
  input  logic               clk_i,
  input  node_wr_t           wr_i,
  input  node_rd_t           rd_i,
  output logic [PRICE_W-1:0] value_a_o,
  output logic [PRICE_W-1:0] value_b_o,
  output logic [PRICE_W-1:0] spot_a_o
);

  // Node values and node spot prices of the level being worked on.
  logic [PRICE_W-1:0] value_mem [NODE_DEPTH];
  logic [PRICE_W-1:0] spot_mem  [NODE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      value_mem[wr_i.addr] <= wr_i.value;
    end
    if (wr_i.en && wr_i.spot_en) begin
      spot_mem[wr_i.addr] <= wr_i.spot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      value_a_o <= value_mem[rd_i.addr_a];
      value_b_o <= value_mem[rd_i.addr_b];
      spot_a_o  <= spot_mem[rd_i.addr_a];
    end
  end

endmodule

@@ rtl/core/binomial_tree_option_pricer.sv @@
// From the accepting edge to a valid result: the leaves are generated first, then each
// of the N(N+1)/2 interior nodes is rolled back (American mode adds a spot-price step
// per node), and then the result is posted.
// Throughput: one request in flight, taken in the idle cycle after the result is posted;
// a result still waiting on rsp.ready holds the sequencer in its final state.
// Reset (rst_ni low, asynchronous) loads the register defaults and idles the
// sequencer; the node store is not cleared, since every request writes all leaves first.
module binomial_tree_option_pricer import bopr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bopr_req_if.sink              req,
  bopr_rsp_if.source            rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers. Software computes the factors; the block only
  // clamps the step count and the probability.
  logic [FACT_W-1:0]   up_q, down_q;
  logic [PROB_W-1:0]   prob_q, disc_q;
  logic [NSTEPS_W-1:0] steps_q;
  logic                amer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= FACT_W'(ONE_Q30);
      down_q  <= FACT_W'(ONE_Q30);
      prob_q  <= ONE_Q30 >> 1;
      disc_q  <= ONE_Q30;
      steps_q <= NSTEPS_W'(64);
      amer_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UP_FACTOR:   up_q    <= cfg_data_i[FACT_W-1:0];
        CFG_DOWN_FACTOR: down_q  <= cfg_data_i[FACT_W-1:0];
        CFG_UP_PROB:     prob_q  <= cfg_data_i[PROB_W-1:0];
        CFG_DISCOUNT:    disc_q  <= cfg_data_i[PROB_W-1:0];
        CFG_NUM_STEPS:   steps_q <= cfg_data_i[NSTEPS_W-1:0];
        CFG_EXERCISE:    amer_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective step count: zero acts as one, anything above the store acts as the maximum.
  logic [STEP_W-1:0] n_eff;
  logic [PROB_W-1:0] p_eff, q_eff;

  always_comb begin
    if (steps_q == '0) begin
      n_eff = STEP_W'(1);
    end else if (32'(steps_q) > 32'(MAX_STEPS)) begin
      n_eff = STEP_W'(MAX_STEPS);
    end else begin
      n_eff = STEP_W'(steps_q);
    end
    p_eff = (prob_q > ONE_Q30) ? ONE_Q30 : prob_q;
    q_eff = ONE_Q30 - p_eff;
  end

  // Sequencer and datapath registers.
  state_e             state_q, state_d;
  logic [STEP_W-1:0]  idx_q;      // node index within the level
  logic [LVL_W-1:0]   lvl_q;      // current level during roll-back
  logic [STEP_W-1:0]  k_q;        // up moves still to apply to the current leaf
  logic [PRICE_W-1:0] strike_q, diag_q, x_q;
  logic [PROD_W-1:0]  prod_q, acc_q;
  logic [PRICE_W-1:0] mix_q, cont_q, spot_q, res_q;
  logic               rsp_valid_q;
  logic [PRICE_W-1:0] rsp_price_q;

  logic [PRICE_W-1:0] rd_value_a, rd_value_b, rd_spot_a;
  node_wr_t           wr;
  node_rd_t           rd;

  // The single multiplier shared by every phase.
  logic [FACT_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [PRICE_W-1:0] mul_q30;

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mul_q30 = q30_scale(mul_p);

  logic               req_fire, rsp_fire;
  logic               leaf_last, node_last, lvl_last;
  logic [PRICE_W-1:0] ex_val, wb_val;

  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp_valid_q && rsp.ready;
  assign leaf_last = (idx_q == n_eff);
  assign node_last = (idx_q == STEP_W'(lvl_q));
  assign lvl_last  = (lvl_q == '0);

  // American nodes take the larger of continuation and early exercise.
  assign ex_val = call_payoff(spot_q, strike_q);
  assign wb_val = (amer_q && (ex_val > cont_q)) ? ex_val : cont_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req.valid) state_d = S_L_UP;
      S_L_UP:   if (k_q == '0) state_d = S_L_WR;
      S_L_WR:   state_d = leaf_last ? S_B_RD : S_L_UP;
      S_B_RD:   state_d = S_B_MP;
      S_B_MP:   state_d = S_B_MQ;
      S_B_MQ:   state_d = S_B_SUM;
      S_B_SUM:  state_d = S_B_DISC;
      S_B_DISC: state_d = amer_q ? S_B_SPOT : S_B_WB;
      S_B_SPOT: state_d = S_B_WB;
      S_B_WB:   state_d = (node_last && lvl_last) ? S_DONE : S_B_RD;
      S_DONE:   if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Multiplier operands and node store requests.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    wr         = '0;
    rd         = '0;
    rd.addr_a  = idx_q;
    rd.addr_b  = idx_q + STEP_W'(1);
    wr.addr    = idx_q;
    case (state_q)
      S_L_UP: begin
        mul_a = x_q;
        mul_b = up_q;
      end
      S_L_WR: begin
        // Next diagonal leaf is one more down move from the previous diagonal.
        mul_a      = diag_q;
        mul_b      = down_q;
        wr.en      = 1'b1;
        wr.value   = call_payoff(x_q, strike_q);
        wr.spot_en = 1'b1;
        wr.spot    = x_q;
      end
      S_B_RD: begin
        rd.en = 1'b1;
      end
      S_B_MP: begin
        mul_a = FACT_W'(p_eff);
        mul_b = rd_value_a;
      end
      S_B_MQ: begin
        mul_a = FACT_W'(q_eff);
        mul_b = rd_value_b;
      end
      S_B_DISC: begin
        mul_a = mix_q;
        mul_b = FACT_W'(disc_q);
      end
      S_B_SPOT: begin
        mul_a = rd_spot_a;
        mul_b = down_q;
      end
      S_B_WB: begin
        wr.en      = 1'b1;
        wr.value   = wb_val;
        wr.spot_en = amer_q;
        wr.spot    = spot_q;
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      lvl_q       <= '0;
      k_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            idx_q <= '0;
            k_q   <= n_eff;
          end
        end
        S_L_UP: begin
          if (k_q != '0) k_q <= k_q - STEP_W'(1);
        end
        S_L_WR: begin
          if (leaf_last) begin
            idx_q <= '0;
            lvl_q <= LVL_W'(n_eff - STEP_W'(1));
          end else begin
            idx_q <= idx_q + STEP_W'(1);
            k_q   <= n_eff - idx_q - STEP_W'(1);
          end
        end
        S_B_WB: begin
          if (node_last) begin
            idx_q <= '0;
            if (!lvl_last) lvl_q <= lvl_q - LVL_W'(1);
          end else begin
            idx_q <= idx_q + STEP_W'(1);
          end
        end
        default: ;
      endcase
      if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          strike_q <= req.strike_price;
          diag_q   <= req.spot_price;
          x_q      <= req.spot_price;
        end
      end
      S_L_UP: begin
        if (k_q != '0) x_q <= mul_q30;
      end
      S_L_WR: begin
        diag_q <= mul_q30;
        x_q    <= mul_q30;
      end
      S_B_MP:   prod_q <= mul_p;
      S_B_MQ: begin
        prod_q <= mul_p;
        acc_q  <= prod_q;
      end
      S_B_SUM:  mix_q  <= q30_scale(acc_q + prod_q);
      S_B_DISC: cont_q <= mul_q30;
      S_B_SPOT: spot_q <= mul_q30;
      S_B_WB: begin
        if (node_last && lvl_last) res_q <= wb_val;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp.ready) rsp_price_q <= res_q;
      end
      default: ;
    endcase
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.option_price = rsp_price_q;

  // Writes to a node and reads of the next node never touch the same entry in
  // one cycle, and a level starts only after its last write has landed, so the
  // store needs no forwarding.
  bopr_node_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .value_a_o (rd_value_a),
    .value_b_o (rd_value_b),
    .spot_a_o  (rd_spot_a)
  );

  // A new result appears only after the sequencer reached its final state.
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised without finishing the tree");

  // Roll-back never reads past the end of the current level.
  a_node_in_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_B_RD) |-> (idx_q <= STEP_W'(lvl_q)))
    else $error("node index beyond level");

  // Leaf generation stays within the tree.
  a_leaf_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_L_WR) |-> (idx_q <= n_eff))
    else $error("leaf index beyond tree");

  // The store is written only while a request is being worked on.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !wr.en)
    else $error("node store written while idle");

endmodule
